### rtl/core/r2bfly_pkg.sv
// Shared types and constants of the radix-2 twiddle butterfly.
package r2bfly_pkg;

   // Field widths that are fixed by the interface.
   localparam int INDEX_WIDTH       = 11;
   localparam int START_WIDTH       = 16;
   localparam int MERGE_LOG2_WIDTH  = 4;
   localparam int CSR_INDEX_WIDTH   = 2;
   localparam int CSR_DATA_WIDTH    = 16;

   // Twiddle format: unsigned magnitude Q1.15 with one extra bit to hold +1.0.
   localparam int TWIDDLE_FRAC      = 15;
   localparam int TWIDDLE_MAG_WIDTH = 17;
   localparam logic [TWIDDLE_MAG_WIDTH-1:0] TWIDDLE_ONE  = 17'd32768;
   localparam logic [TWIDDLE_MAG_WIDTH-1:0] TWIDDLE_HALF = 17'd16384;

   // Reset value of the merge length register.
   localparam logic [MERGE_LOG2_WIDTH-1:0] MERGE_LOG2_RESET = 4'd1;

   // Fixed-point pi in Q60, used to build the cosine table.
   localparam logic [63:0] PI_Q60    = 64'h3243F6A8885A308D;
   localparam int          ROM_FRAC  = 60;
   localparam int          ROM_SHIFT = 45;

   // Register map of the configuration port.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_TWIDDLE_START     = 2'd0,
      CSR_MERGE_LENGTH_LOG2 = 2'd1
   } csr_index_type;

   // Quadrant of the twiddle angle.
   typedef enum logic [1:0] {
      QUAD_FIRST  = 2'd0,
      QUAD_SECOND = 2'd1,
      QUAD_THIRD  = 2'd2,
      QUAD_FOURTH = 2'd3
   } quadrant_type;

endpackage

### rtl/core/radix2_butterfly_with_twiddle_top.sv
// Radix-2 DIT butterfly with a pipelined twiddle lookup and complex multiply.
// Throughput: one beat per cycle; a full stage holds only while the stage after it holds.
// The twiddle ROM is read at two addresses in one registered stage (cosine and sine).
// Reset clears all valid bits, twiddle_start to 0 and merge_length_log2 to 1.
// The ROM is constant, so no clearing pass follows reset.
module radix2_butterfly_with_twiddle_top #(
   parameter int MAX_MERGE_LOG2 = 12,
   parameter int SAMPLE_WIDTH   = 16
) (
   input  logic                                        clock,
   input  logic                                        reset,
   // Configuration write port.
   input  logic                                        csr_we,
   input  logic [r2bfly_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  logic [r2bfly_pkg::CSR_DATA_WIDTH-1:0]       csr_wdata,
   // Request channel.
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  logic [r2bfly_pkg::INDEX_WIDTH-1:0]          req_element_index,
   input  logic signed [SAMPLE_WIDTH-1:0]              req_a_re,
   input  logic signed [SAMPLE_WIDTH-1:0]              req_a_im,
   input  logic signed [SAMPLE_WIDTH-1:0]              req_b_re,
   input  logic signed [SAMPLE_WIDTH-1:0]              req_b_im,
   // Response channel.
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic signed [SAMPLE_WIDTH+1:0]              rsp_sum_re,
   output logic signed [SAMPLE_WIDTH+1:0]              rsp_sum_im,
   output logic signed [SAMPLE_WIDTH+1:0]              rsp_diff_re,
   output logic signed [SAMPLE_WIDTH+1:0]              rsp_diff_im
);

   localparam int STAGES   = 7;
   localparam int QTR      = 1 << MAX_MERGE_LOG2;
   localparam int ADDR_W   = MAX_MERGE_LOG2 + 1;
   localparam int SH_W     = $clog2(MAX_MERGE_LOG2 + 3);
   localparam int SUM_W    = r2bfly_pkg::START_WIDTH + 1;
   localparam int MAG_W    = r2bfly_pkg::TWIDDLE_MAG_WIDTH;
   localparam int TW_W     = MAG_W + 1;
   localparam int OUT_W    = SAMPLE_WIDTH + 2;
   localparam int PROD_W   = SAMPLE_WIDTH + TW_W;
   localparam int ACC_W    = PROD_W + 1;
   localparam int FRAC     = r2bfly_pkg::TWIDDLE_FRAC;

   localparam logic signed [TW_W-1:0]  W_POS_ONE  = TW_W'(r2bfly_pkg::TWIDDLE_ONE);
   localparam logic signed [TW_W-1:0]  W_NEG_ONE  = -W_POS_ONE;
   localparam logic signed [TW_W-1:0]  W_POS_HALF = TW_W'(r2bfly_pkg::TWIDDLE_HALF);
   localparam logic signed [TW_W-1:0]  W_NEG_HALF = -W_POS_HALF;
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC - 1);

   typedef logic [MAG_W-1:0] rom_type [QTR+1];

   // Fixed-point multiply of two Q60 values, truncated back to Q60.
   function automatic logic [63:0] mul_q60(input logic [63:0] x, input logic [63:0] y);
      logic [127:0] prod;
      prod = {64'd0, x} * {64'd0, y};
      return prod[r2bfly_pkg::ROM_FRAC+63:r2bfly_pkg::ROM_FRAC];
   endfunction

   // Divides a Taylor term by (2n-1)(2n); the terms vanish well before n = 16.
   function automatic logic [63:0] taylor_div(input logic [63:0] term, input int n);
      logic [63:0] res;
      case (n)
         1:       res = term / 64'd2;
         2:       res = term / 64'd12;
         3:       res = term / 64'd30;
         4:       res = term / 64'd56;
         5:       res = term / 64'd90;
         6:       res = term / 64'd132;
         7:       res = term / 64'd182;
         8:       res = term / 64'd240;
         9:       res = term / 64'd306;
         10:      res = term / 64'd380;
         11:      res = term / 64'd462;
         12:      res = term / 64'd552;
         13:      res = term / 64'd650;
         14:      res = term / 64'd756;
         15:      res = term / 64'd870;
         16:      res = term / 64'd992;
         default: res = 64'd0;
      endcase
      return res;
   endfunction

   // One quarter wave of cosine, rounded half up to Q1.15 with +1.0 held exactly.
   function automatic logic [MAG_W-1:0] cos_entry(input int j);
      logic [63:0]        step;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic signed [63:0] r;
      step = (r2bfly_pkg::PI_Q60 >> 1) >> MAX_MERGE_LOG2;
      x    = step * 64'(j);
      x2   = mul_q60(x, x);
      term = 64'd1 << r2bfly_pkg::ROM_FRAC;
      sum  = signed'(term);
      for (int n = 1; n <= 16; n++) begin
         if (term != 64'd0) begin
            term = taylor_div(mul_q60(term, x2), n);
            if (n % 2 == 1) begin
               sum = sum - signed'(term);
            end else begin
               sum = sum + signed'(term);
            end
         end
      end
      if (sum < 0) begin
         sum = 64'sd0;
      end
      r = (sum + (64'sd1 <<< (r2bfly_pkg::ROM_SHIFT - 1))) >>> r2bfly_pkg::ROM_SHIFT;
      if (r > 64'(r2bfly_pkg::TWIDDLE_ONE)) begin
         r = 64'(r2bfly_pkg::TWIDDLE_ONE);
      end
      return r[MAG_W-1:0];
   endfunction

   function automatic rom_type build_rom();
      rom_type tab;
      for (int j = 0; j <= QTR; j++) begin
         tab[j] = cos_entry(j);
      end
      return tab;
   endfunction

   localparam rom_type COS_ROM = build_rom();

   // Configuration registers.
   logic [r2bfly_pkg::START_WIDTH-1:0]      twiddle_start_ff;
   logic [r2bfly_pkg::MERGE_LOG2_WIDTH-1:0] merge_log2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         twiddle_start_ff <= '0;
         merge_log2_ff    <= r2bfly_pkg::MERGE_LOG2_RESET;
      end else if (csr_we) begin
         case (csr_index)
            r2bfly_pkg::CSR_TWIDDLE_START: begin
               twiddle_start_ff <= csr_wdata[r2bfly_pkg::START_WIDTH-1:0];
            end
            r2bfly_pkg::CSR_MERGE_LENGTH_LOG2: begin
               merge_log2_ff <= csr_wdata[r2bfly_pkg::MERGE_LOG2_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Pipeline control: a stage loads when it is empty or its successor loads.
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] adv;

   always_comb begin
      adv[STAGES-1] = !valid_ff[STAGES-1] || rsp_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int k = 1; k < STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   assign req_ready = adv[0];
   assign rsp_valid = valid_ff[STAGES-1];

   // Operand delay lines: a is needed up to the final add, b up to the multiply.
   logic signed [SAMPLE_WIDTH-1:0] a_re_ff [6];
   logic signed [SAMPLE_WIDTH-1:0] a_im_ff [6];
   logic signed [SAMPLE_WIDTH-1:0] b_re_ff [4];
   logic signed [SAMPLE_WIDTH-1:0] b_im_ff [4];

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         a_re_ff[0] <= req_a_re;
         a_im_ff[0] <= req_a_im;
         b_re_ff[0] <= req_b_re;
         b_im_ff[0] <= req_b_im;
      end
      for (int k = 1; k < 6; k++) begin
         if (adv[k]) begin
            a_re_ff[k] <= a_re_ff[k-1];
            a_im_ff[k] <= a_im_ff[k-1];
         end
      end
      for (int k = 1; k < 4; k++) begin
         if (adv[k]) begin
            b_re_ff[k] <= b_re_ff[k-1];
            b_im_ff[k] <= b_im_ff[k-1];
         end
      end
   end

   // Stage 0: twiddle position p = (start + i) mod M and the scaling shift.
   logic [SUM_W-1:0]          pos_sum;
   logic [SH_W-1:0]           merge_eff;
   logic [MAX_MERGE_LOG2-1:0] pos_in;
   logic [SH_W-1:0]           shift_in;
   logic [MAX_MERGE_LOG2-1:0] pos_ff;
   logic [SH_W-1:0]           shift_ff;

   always_comb begin
      pos_sum = {1'b0, twiddle_start_ff} + SUM_W'(req_element_index);
      if (merge_log2_ff > MAX_MERGE_LOG2) begin
         merge_eff = SH_W'(MAX_MERGE_LOG2);
      end else begin
         merge_eff = SH_W'(merge_log2_ff);
      end
      pos_in   = pos_sum[MAX_MERGE_LOG2-1:0] & ~({MAX_MERGE_LOG2{1'b1}} << merge_eff);
      shift_in = SH_W'(MAX_MERGE_LOG2 + 2) - merge_eff;
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         pos_ff   <= pos_in;
         shift_ff <= shift_in;
      end
   end

   // Stage 1: scale to the table size, split into quadrant and offset.
   logic [MAX_MERGE_LOG2+1:0]     scaled;
   logic [ADDR_W-1:0]             addr_lo_in;
   logic [ADDR_W-1:0]             addr_hi_in;
   r2bfly_pkg::quadrant_type      quad_in;
   logic [ADDR_W-1:0]             addr_lo_ff;
   logic [ADDR_W-1:0]             addr_hi_ff;
   r2bfly_pkg::quadrant_type      quad1_ff;

   always_comb begin
      scaled     = {2'b00, pos_ff} << shift_ff;
      quad_in    = r2bfly_pkg::quadrant_type'(scaled[MAX_MERGE_LOG2+1:MAX_MERGE_LOG2]);
      addr_lo_in = {1'b0, scaled[MAX_MERGE_LOG2-1:0]};
      addr_hi_in = ADDR_W'(QTR) - addr_lo_in;
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         addr_lo_ff <= addr_lo_in;
         addr_hi_ff <= addr_hi_in;
         quad1_ff   <= quad_in;
      end
   end

   // Stage 2: registered two-address read of the cosine table.
   logic [MAG_W-1:0]         rom_lo_ff;
   logic [MAG_W-1:0]         rom_hi_ff;
   r2bfly_pkg::quadrant_type quad2_ff;

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         rom_lo_ff <= COS_ROM[addr_lo_ff];
         rom_hi_ff <= COS_ROM[addr_hi_ff];
         quad2_ff  <= quad1_ff;
      end
   end

   // Stage 3: fold the quadrant into signed twiddle wr = cos, wi = -sin.
   logic signed [TW_W-1:0] lo_s;
   logic signed [TW_W-1:0] hi_s;
   logic signed [TW_W-1:0] wr_in;
   logic signed [TW_W-1:0] wi_in;
   logic signed [TW_W-1:0] wr_ff;
   logic signed [TW_W-1:0] wi_ff;

   always_comb begin
      lo_s = signed'({1'b0, rom_lo_ff});
      hi_s = signed'({1'b0, rom_hi_ff});
      case (quad2_ff)
         r2bfly_pkg::QUAD_FIRST: begin
            wr_in = lo_s;
            wi_in = -hi_s;
         end
         r2bfly_pkg::QUAD_SECOND: begin
            wr_in = -hi_s;
            wi_in = -lo_s;
         end
         r2bfly_pkg::QUAD_THIRD: begin
            wr_in = -lo_s;
            wi_in = hi_s;
         end
         default: begin
            wr_in = hi_s;
            wi_in = lo_s;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         wr_ff <= wr_in;
         wi_ff <= wi_in;
      end
   end

   // Stage 4: the four partial products of b times w.
   logic signed [PROD_W-1:0] prod_rr_ff;
   logic signed [PROD_W-1:0] prod_ii_ff;
   logic signed [PROD_W-1:0] prod_ri_ff;
   logic signed [PROD_W-1:0] prod_ir_ff;

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         prod_rr_ff <= PROD_W'(b_re_ff[3]) * PROD_W'(wr_ff);
         prod_ii_ff <= PROD_W'(b_im_ff[3]) * PROD_W'(wi_ff);
         prod_ri_ff <= PROD_W'(b_re_ff[3]) * PROD_W'(wi_ff);
         prod_ir_ff <= PROD_W'(b_im_ff[3]) * PROD_W'(wr_ff);
      end
   end

   // Stage 5: combine and round half up to the sample scale.
   logic signed [ACC_W-1:0] acc_re;
   logic signed [ACC_W-1:0] acc_im;
   logic signed [OUT_W-1:0] t_re_ff;
   logic signed [OUT_W-1:0] t_im_ff;

   always_comb begin
      acc_re = ACC_W'(prod_rr_ff) - ACC_W'(prod_ii_ff) + ROUND_HALF;
      acc_im = ACC_W'(prod_ri_ff) + ACC_W'(prod_ir_ff) + ROUND_HALF;
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         t_re_ff <= acc_re[FRAC+OUT_W-1:FRAC];
         t_im_ff <= acc_im[FRAC+OUT_W-1:FRAC];
      end
   end

   // Stage 6: butterfly sum and difference into the output register.
   logic signed [OUT_W-1:0] sum_re_ff;
   logic signed [OUT_W-1:0] sum_im_ff;
   logic signed [OUT_W-1:0] diff_re_ff;
   logic signed [OUT_W-1:0] diff_im_ff;

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         sum_re_ff  <= OUT_W'(a_re_ff[5]) + t_re_ff;
         sum_im_ff  <= OUT_W'(a_im_ff[5]) + t_im_ff;
         diff_re_ff <= OUT_W'(a_re_ff[5]) - t_re_ff;
         diff_im_ff <= OUT_W'(a_im_ff[5]) - t_im_ff;
      end
   end

   assign rsp_sum_re  = sum_re_ff;
   assign rsp_sum_im  = sum_im_ff;
   assign rsp_diff_re = diff_re_ff;
   assign rsp_diff_im = diff_im_ff;

   // An empty output register must never hold back the request side.
   a_ready_when_out_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request side stalled while the output register is empty");

   // A folded twiddle never exceeds unit magnitude.
   a_twiddle_bounded: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] |-> (wr_ff <= W_POS_ONE && wr_ff >= W_NEG_ONE &&
                       wi_ff <= W_POS_ONE && wi_ff >= W_NEG_ONE))
      else $error("twiddle component out of range");

   // A unit-circle twiddle always has one component of at least one half.
   a_twiddle_on_circle: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] |-> (wr_ff >= W_POS_HALF || wr_ff <= W_NEG_HALF ||
                       wi_ff >= W_POS_HALF || wi_ff <= W_NEG_HALF))
      else $error("twiddle lookup returned a point far inside the unit circle");

endmodule
